@@ design/pnc_pkg.sv @@
// Shared constants, types and codes of the palette nearest-colour match unit.
package pnc_pkg;

    localparam int unsigned PALETTE_ENTRIES = 256;
    localparam int unsigned ADDR_W          = $clog2(PALETTE_ENTRIES);
    localparam int unsigned RGB_W           = 24;
    localparam int unsigned DIST_W          = 10;

    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_MATCH  = 2'd1;
    localparam logic [1:0] KIND_LOOKUP = 2'd2;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

endpackage

@@ design/pnc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pnc_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/pnc_l1dist.sv @@
// Sum of absolute channel differences between two RGB888 colours.
module pnc_l1dist (
    input  pnc_pkg::t_rgb               i_a,
    input  pnc_pkg::t_rgb               i_b,
    output logic [pnc_pkg::DIST_W-1:0] o_dist
);

    logic [7:0] d_red;
    logic [7:0] d_green;
    logic [7:0] d_blue;

    assign d_red   = (i_a.red   > i_b.red)   ? i_a.red   - i_b.red   : i_b.red   - i_a.red;
    assign d_green = (i_a.green > i_b.green) ? i_a.green - i_b.green : i_b.green - i_a.green;
    assign d_blue  = (i_a.blue  > i_b.blue)  ? i_a.blue  - i_b.blue  : i_b.blue  - i_a.blue;

    assign o_dist = pnc_pkg::DIST_W'(d_red) + pnc_pkg::DIST_W'(d_green)
                  + pnc_pkg::DIST_W'(d_blue);

endmodule

@@ design/palette_nearest_color_match_core.sv @@
// Top level of the palette nearest-colour match unit.
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+----------------------------------------------------
//  in      | i_valid | o_ready | i_kind, i_entry_index, i_color_red/green/blue
//  out     | o_valid | i_ready | o_found_index, o_out_red/green/blue, o_match_distance
//
// Write beat: no result. Lookup: through ST_LOOK and ST_FIN to the output register.
// Match: a scan of every entry, then ST_FIN; the palette RAM's single read port delivers
// one entry per cycle to the distance compare.
// Reset clears the entry valid bits at once, so the palette reads as zero; no sweep.
// A finished result waits in the output register; a new beat is taken meanwhile,
// and the next result holds in the final state until the output register frees.
module palette_nearest_color_match_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_entry_index,
    input  logic [7:0] i_color_red,
    input  logic [7:0] i_color_green,
    input  logic [7:0] i_color_blue,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_found_index,
    output logic [7:0] o_out_red,
    output logic [7:0] o_out_green,
    output logic [7:0] o_out_blue,
    output logic [9:0] o_match_distance
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_LOOK = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]                   r_state, n_state;
    logic [pnc_pkg::ADDR_W-1:0]   r_cmp_idx, n_cmp_idx;
    pnc_pkg::t_rgb                r_pix, n_pix;
    logic [7:0]                   r_best_idx, n_best_idx;
    pnc_pkg::t_rgb                r_best_rgb, n_best_rgb;
    logic [pnc_pkg::DIST_W-1:0]   r_best_dist, n_best_dist;
    logic [7:0]                   r_look_idx, n_look_idx;
    logic                         r_look_ok, n_look_ok;
    logic                         r_o_valid, n_o_valid;
    logic [7:0]                   r_o_idx, n_o_idx;
    pnc_pkg::t_rgb                r_o_rgb, n_o_rgb;
    logic [pnc_pkg::DIST_W-1:0]   r_o_dist, n_o_dist;
    logic [pnc_pkg::PALETTE_ENTRIES-1:0] r_valid;
    logic                         r_rd_vld;

    logic                         accept;
    logic                         idx_ok;
    logic                         we;
    logic [pnc_pkg::ADDR_W-1:0]   rd_addr;
    logic [pnc_pkg::RGB_W-1:0]    rd_data;
    pnc_pkg::t_rgb                entry;
    pnc_pkg::t_rgb                in_rgb;
    logic [pnc_pkg::DIST_W-1:0]   cand_dist;

    assign o_ready = (r_state == ST_IDLE);
    assign accept  = i_valid && o_ready;
    assign idx_ok  = {1'b0, i_entry_index} < 9'(pnc_pkg::PALETTE_ENTRIES);
    assign we      = accept && (i_kind == pnc_pkg::KIND_WRITE) && idx_ok;
    assign in_rgb  = '{red: i_color_red, green: i_color_green, blue: i_color_blue};

    // during a scan, fetch the entry after the one being compared
    always_comb begin
        if (r_state == ST_SCAN) begin
            rd_addr = r_cmp_idx + pnc_pkg::ADDR_W'(1);
        end else if (i_kind == pnc_pkg::KIND_MATCH) begin
            rd_addr = '0;
        end else begin
            rd_addr = i_entry_index[pnc_pkg::ADDR_W-1:0];
        end
    end

    pnc_ram #(
        .WIDTH (pnc_pkg::RGB_W),
        .DEPTH (pnc_pkg::PALETTE_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (i_entry_index[pnc_pkg::ADDR_W-1:0]),
        .i_wdata (in_rgb),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // never-written entries read as zero
    assign entry = r_rd_vld ? pnc_pkg::t_rgb'(rd_data) : '0;

    pnc_l1dist u_dist (
        .i_a    (entry),
        .i_b    (r_pix),
        .o_dist (cand_dist)
    );

    always_comb begin
        n_state     = r_state;
        n_cmp_idx   = r_cmp_idx;
        n_pix       = r_pix;
        n_best_idx  = r_best_idx;
        n_best_rgb  = r_best_rgb;
        n_best_dist = r_best_dist;
        n_look_idx  = r_look_idx;
        n_look_ok   = r_look_ok;
        n_o_valid   = r_o_valid;
        n_o_idx     = r_o_idx;
        n_o_rgb     = r_o_rgb;
        n_o_dist    = r_o_dist;

        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_kind)
                        pnc_pkg::KIND_MATCH: begin
                            n_pix     = in_rgb;
                            n_cmp_idx = '0;
                            n_state   = ST_SCAN;
                        end
                        pnc_pkg::KIND_LOOKUP: begin
                            n_look_idx = i_entry_index;
                            n_look_ok  = idx_ok;
                            n_state    = ST_LOOK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // entry 0 always seeds the best, whatever r_best_dist holds
                if ((r_cmp_idx == '0) || (cand_dist < r_best_dist)) begin
                    n_best_idx  = 8'(r_cmp_idx);
                    n_best_rgb  = entry;
                    n_best_dist = cand_dist;
                end
                if (r_cmp_idx == pnc_pkg::ADDR_W'(pnc_pkg::PALETTE_ENTRIES - 1)) begin
                    n_state = ST_FIN;
                end else begin
                    n_cmp_idx = r_cmp_idx + pnc_pkg::ADDR_W'(1);
                end
            end
            ST_LOOK: begin
                n_best_idx  = r_look_idx;
                n_best_rgb  = r_look_ok ? entry : '0;
                n_best_dist = '0;
                n_state     = ST_FIN;
            end
            ST_FIN: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid = 1'b1;
                    n_o_idx   = r_best_idx;
                    n_o_rgb   = r_best_rgb;
                    n_o_dist  = r_best_dist;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
            r_valid   <= '0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            if (we) begin
                r_valid[i_entry_index[pnc_pkg::ADDR_W-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx   <= n_cmp_idx;
        r_pix       <= n_pix;
        r_best_idx  <= n_best_idx;
        r_best_rgb  <= n_best_rgb;
        r_best_dist <= n_best_dist;
        r_look_idx  <= n_look_idx;
        r_look_ok   <= n_look_ok;
        r_o_idx     <= n_o_idx;
        r_o_rgb     <= n_o_rgb;
        r_o_dist    <= n_o_dist;
        r_rd_vld    <= r_valid[rd_addr];
    end

    assign o_valid          = r_o_valid;
    assign o_found_index    = r_o_idx;
    assign o_out_red        = r_o_rgb.red;
    assign o_out_green      = r_o_rgb.green;
    assign o_out_blue       = r_o_rgb.blue;
    assign o_match_distance = r_o_dist;

`ifndef NO_ASSERTIONS
    // best distance only falls once the scan is past entry 0
    a_best_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && $past(r_state) == ST_SCAN && $past(r_cmp_idx) != '0)
        |-> (r_best_dist <= $past(r_best_dist)))
        else $error("best distance rose during scan");

    a_lookup_dist_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && $past(r_state) == ST_LOOK) |-> (r_best_dist == '0))
        else $error("lookup result carries a distance");

    // a held result must not overwrite a stalled output beat
    a_fin_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && r_o_valid && !i_ready) |=> (r_state == ST_FIN))
        else $error("result left final state while output stalled");
`endif

endmodule

@@ sim/pnc_tb_pkg.sv @@
// Palette shadow copy, nearest-colour prediction and reply scoreboard for the testbench.
package pnc_tb_pkg;
    import pnc_pkg::*;

    // kind code that the unit has no use for
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int unsigned FAR_DIST = 765;
    localparam int unsigned PRINT_CAP = 100;

    typedef struct packed {
        logic [7:0]        entry;
        t_rgb              colour;
        logic [DIST_W-1:0] distance;
    } t_reply;

    class palette_scoreboard;
        t_rgb   shadow_palette [PALETTE_ENTRIES];
        t_reply replies_due [$];
        int     errors;

        function new();
            foreach (shadow_palette[i]) shadow_palette[i] = '0;
            errors = 0;
        endfunction

        static function int unsigned chan_gap(logic [7:0] a, logic [7:0] b);
            return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
        endfunction

        static function int unsigned l1_distance(t_rgb a, t_rgb b);
            return chan_gap(a.red, b.red) + chan_gap(a.green, b.green)
                 + chan_gap(a.blue, b.blue);
        endfunction

        function void report(string what);
            if (errors < PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endfunction

        // Called for every accepted input beat, in acceptance order.
        function void note_request(logic [1:0] kind, logic [7:0] idx, t_rgb pixel);
            int unsigned best;
            int unsigned best_dist;
            int unsigned d;
            t_reply      want;
            case (kind)
                KIND_WRITE: begin
                    if (idx < PALETTE_ENTRIES) shadow_palette[idx] = pixel;
                end
                KIND_MATCH: begin
                    // scan from entry 0, strict improvement only, start at the far limit
                    best      = 0;
                    best_dist = FAR_DIST;
                    for (int i = 0; i < PALETTE_ENTRIES; i++) begin
                        d = l1_distance(shadow_palette[i], pixel);
                        if (d < best_dist) begin
                            best_dist = d;
                            best      = i;
                        end
                    end
                    want.entry    = best[7:0];
                    want.colour   = shadow_palette[best];
                    want.distance = best_dist[DIST_W-1:0];
                    replies_due.push_back(want);
                end
                KIND_LOOKUP: begin
                    want.entry    = idx;
                    want.colour   = (idx < PALETTE_ENTRIES) ? shadow_palette[idx] : '0;
                    want.distance = '0;
                    replies_due.push_back(want);
                end
                default: ;
            endcase
        endfunction

        function void check_reply(t_reply got);
            t_reply want;
            if (replies_due.size() == 0) begin
                report($sformatf("reply with nothing due, found_index %0d", got.entry));
                return;
            end
            want = replies_due.pop_front();
            if (got.entry != want.entry)
                report($sformatf("found_index %0d, want %0d", got.entry, want.entry));
            if (got.colour.red != want.colour.red)
                report($sformatf("out_red %0d, want %0d", got.colour.red, want.colour.red));
            if (got.colour.green != want.colour.green)
                report($sformatf("out_green %0d, want %0d",
                                 got.colour.green, want.colour.green));
            if (got.colour.blue != want.colour.blue)
                report($sformatf("out_blue %0d, want %0d",
                                 got.colour.blue, want.colour.blue));
            if (got.distance != want.distance)
                report($sformatf("match_distance %0d, want %0d",
                                 got.distance, want.distance));
        endfunction

        function int pending();
            return replies_due.size();
        endfunction
    endclass

endpackage

@@ sim/testbench.sv @@
// Top-level testbench of the palette nearest-colour match unit.
module testbench;
    import pnc_pkg::*;
    import pnc_tb_pkg::*;

    localparam int unsigned RANDOM_BEATS  = 1000;
    localparam int unsigned SETTLE_CYCLES = PALETTE_ENTRIES + 40;
    localparam int unsigned CYCLE_LIMIT   = 1_500_000;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_valid       = 1'b0;
    logic [1:0] i_kind        = KIND_WRITE;
    logic [7:0] i_entry_index = '0;
    logic [7:0] i_color_red   = '0;
    logic [7:0] i_color_green = '0;
    logic [7:0] i_color_blue  = '0;
    logic       i_ready       = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_found_index;
    logic [7:0] o_out_red;
    logic [7:0] o_out_green;
    logic [7:0] o_out_blue;
    logic [9:0] o_match_distance;

    palette_scoreboard sb = new();
    int unsigned       cycle_count = 0;
    int                tx_calm = 0;
    int                rx_calm = 0;

    always #6 i_clk = ~i_clk;

    palette_nearest_color_match_core u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_kind           (i_kind),
        .i_entry_index    (i_entry_index),
        .i_color_red      (i_color_red),
        .i_color_green    (i_color_green),
        .i_color_blue     (i_color_blue),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_found_index    (o_found_index),
        .o_out_red        (o_out_red),
        .o_out_green      (o_out_green),
        .o_out_blue       (o_out_blue),
        .o_match_distance (o_match_distance)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // random idle gap before each beat, with the odd stretch of back-to-back beats
    function automatic int draw_gap(ref int calm);
        if (calm == 0 && $urandom_range(0, 15) == 0) calm = $urandom_range(10, 40);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        return $urandom_range(0, 3);
    endfunction

    function automatic t_rgb rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        t_rgb c;
        c.red   = r;
        c.green = g;
        c.blue  = b;
        return c;
    endfunction

    // Coarse levels crop up often so that equal distances (ties) happen.
    function automatic logic [7:0] random_channel();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) return 8'd0;
        if (pick == 1) return 8'd255;
        if (pick < 4) return 8'($urandom_range(0, 3) * 85);
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic push_beat(logic [1:0] kind, logic [7:0] idx, t_rgb pixel);
        int gap;
        gap = draw_gap(tx_calm);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_kind        <= kind;
        i_entry_index <= idx;
        i_color_red   <= pixel.red;
        i_color_green <= pixel.green;
        i_color_blue  <= pixel.blue;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(kind, idx, pixel);
    endtask

    initial begin : reply_side
        int     gap;
        t_reply got;
        forever begin
            gap = draw_gap(rx_calm);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            got.entry        = o_found_index;
            got.colour.red   = o_out_red;
            got.colour.green = o_out_green;
            got.colour.blue  = o_out_blue;
            got.distance     = o_match_distance;
            sb.check_reply(got);
        end
    end

    initial begin : stimulus
        int unsigned sent;
        int          pick;
        logic [1:0]  kind;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // cleared palette: exact hit on black, then nothing closer than the far limit
        push_beat(KIND_MATCH, 8'd0, rgb(8'd0, 8'd0, 8'd0));
        push_beat(KIND_MATCH, 8'd255, rgb(8'd255, 8'd255, 8'd255));
        push_beat(KIND_LOOKUP, 8'd255, rgb(8'd255, 8'd255, 8'd255));
        push_beat(KIND_SPARE, 8'd255, rgb(8'd255, 8'd255, 8'd255));
        push_beat(KIND_WRITE, 8'd255, rgb(8'd255, 8'd255, 8'd255));
        push_beat(KIND_MATCH, 8'd7, rgb(8'd255, 8'd255, 8'd255));
        // equal entries: the lower index must win
        push_beat(KIND_WRITE, 8'd10, rgb(8'd10, 8'd20, 8'd30));
        push_beat(KIND_WRITE, 8'd20, rgb(8'd10, 8'd20, 8'd30));
        push_beat(KIND_MATCH, 8'd20, rgb(8'd12, 8'd18, 8'd33));
        push_beat(KIND_WRITE, 8'd0, rgb(8'd200, 8'd100, 8'd50));
        push_beat(KIND_MATCH, 8'd0, rgb(8'd200, 8'd100, 8'd50));
        push_beat(KIND_WRITE, 8'd128, rgb(8'd0, 8'd255, 8'd0));
        push_beat(KIND_MATCH, 8'd128, rgb(8'd0, 8'd255, 8'd0));
        push_beat(KIND_LOOKUP, 8'd10, rgb(8'd0, 8'd0, 8'd0));
        push_beat(KIND_LOOKUP, 8'd128, rgb(8'd0, 8'd0, 8'd0));
        push_beat(KIND_LOOKUP, 8'd0, rgb(8'd0, 8'd0, 8'd0));
        push_beat(KIND_LOOKUP, 8'd255, rgb(8'd0, 8'd0, 8'd0));
        push_beat(KIND_WRITE, 8'd255, rgb(8'd0, 8'd0, 8'd0));
        push_beat(KIND_MATCH, 8'd255, rgb(8'd255, 8'd255, 8'd255));
        push_beat(KIND_SPARE, 8'd0, rgb(8'd0, 8'd0, 8'd0));
        push_beat(KIND_MATCH, 8'd64, rgb(8'd128, 8'd128, 8'd128));

        sent = 0;
        while (sent < RANDOM_BEATS) begin
            pick = $urandom_range(0, 19);
            if (pick < 8)       kind = KIND_WRITE;
            else if (pick < 14) kind = KIND_MATCH;
            else if (pick < 19) kind = KIND_LOOKUP;
            else                kind = KIND_SPARE;
            push_beat(kind, 8'($urandom_range(0, 255)),
                      rgb(random_channel(), random_channel(), random_channel()));
            if (kind != KIND_SPARE) sent++;
        end
        i_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

@@ palette_nearest_color_match_core.f @@
design/pnc_pkg.sv
design/pnc_ram.sv
design/pnc_l1dist.sv
design/palette_nearest_color_match_core.sv
sim/pnc_tb_pkg.sv
sim/testbench.sv
